FILE: rtl/modbus_rtu_frame_checker_macros.svh
// Assertion helpers; each expects clk and rst_n in the enclosing scope.
`ifndef MODBUS_RTU_FRAME_CHECKER_MACROS_SVH
`define MODBUS_RTU_FRAME_CHECKER_MACROS_SVH

// Same-cycle implication.
`define MRFC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MRFC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/mrfc_pkg.sv
`default_nettype none

package mrfc_pkg;

    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [7:0]  READ_FUNC     = 8'h03;
    localparam logic [7:0]  SENSOR_COUNT  = 8'h10;
    localparam logic [7:0]  STATION_RESET = 8'd247;

    typedef logic [2:0] status_t;
    localparam status_t ST_SENSOR = 3'd0;
    localparam status_t ST_VALID  = 3'd1;
    localparam status_t ST_ADDR   = 3'd2;
    localparam status_t ST_CRC    = 3'd3;
    localparam status_t ST_LENGTH = 3'd4;

    // Byte positions inside a frame
    localparam int POS_FUNC     = 1;
    localparam int POS_COUNT    = 2;
    localparam int POS_CRC_BEG  = 2;
    localparam int POS_MIN_LAST = 3;
    localparam int POS_TEMP_HI  = 5;
    localparam int POS_TEMP_LO  = 6;
    localparam int POS_RATE_HI  = 7;
    localparam int POS_RATE_LO  = 8;
    localparam int POS_DO_HI    = 11;
    localparam int POS_DO_LO    = 12;
    localparam int POS_FRESH    = 18;

    // Register port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_STATION = 1'b0;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       is_last;
    } in_item_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  function_code;
        logic [15:0] temperature;
        logic [15:0] dissolved_oxygen;
        logic [15:0] oxygen_rate;
        logic        fresh;
    } result_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/mrfc_channel_ifs.sv
`default_nettype none

interface mrfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       is_last;

    modport source (output valid, frame_byte, is_last, input ready);
    modport sink   (input valid, frame_byte, is_last, output ready);
endinterface

interface mrfc_out_if;
    logic                  valid;
    logic                  ready;
    mrfc_pkg::status_t     status;
    logic [7:0]            function_code;
    logic [15:0]           temperature;
    logic [15:0]           dissolved_oxygen;
    logic [15:0]           oxygen_rate;
    logic                  fresh;

    modport source (output valid, status, function_code, temperature, dissolved_oxygen,
                    oxygen_rate, fresh, input ready);
    modport sink   (input valid, status, function_code, temperature, dissolved_oxygen,
                    oxygen_rate, fresh, output ready);
endinterface

`default_nettype wire

FILE: rtl/mrfc_apb_regs.sv
`default_nettype none

module mrfc_apb_regs (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [mrfc_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [mrfc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [mrfc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready,
    output logic      [7:0]                        station_address
);

    logic [7:0] station_reg;
    logic [7:0] station_next;
    logic       sel_station;

    // Word index is the address above the byte lanes
    assign sel_station = (paddr[mrfc_pkg::APB_ADDR_W-1:2] == mrfc_pkg::REG_STATION);
    assign pready      = 1'b1;

    always_comb
    begin
        station_next = station_reg;
        if (psel && penable && pwrite && sel_station)
            station_next = pwdata[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            station_reg <= mrfc_pkg::STATION_RESET;
        else
            station_reg <= station_next;
    end

    assign prdata = sel_station ? {{(mrfc_pkg::APB_DATA_W-8){1'b0}}, station_reg}
                                : '0;
    assign station_address = station_reg;

endmodule

`default_nettype wire

FILE: rtl/mrfc_frame_core.sv
`default_nettype none

module mrfc_frame_core #(
    parameter int MAX_FRAME = 256
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               advance,
    input  wire mrfc_pkg::in_item_t item,
    input  wire logic [7:0]         station_address,
    output mrfc_pkg::result_t       res
);

    localparam int IDX_W = $clog2(MAX_FRAME + 2);

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       dly0_reg, dly0_next;
    logic [7:0]       dly1_reg, dly1_next;
    logic             addr_ok_reg, addr_ok_next;
    logic [7:0]       func_reg, func_next;
    logic [7:0]       count_reg, count_next;
    logic [15:0]      pend_temp_reg, pend_temp_next;
    logic [15:0]      pend_rate_reg, pend_rate_next;
    logic [15:0]      pend_do_reg, pend_do_next;
    logic             pend_fresh_reg, pend_fresh_next;
    logic [15:0]      held_temp_reg, held_temp_next;
    logic [15:0]      held_rate_reg, held_rate_next;
    logic [15:0]      held_do_reg, held_do_next;

    logic             first;
    logic [15:0]      crc_base;
    logic             len_err;
    logic             crc_ok;
    logic             update;
    mrfc_pkg::status_t status;

    assign first = (idx_reg == '0);

    always_comb
    begin
        // Start of frame: restart the CRC, clear the per-frame state and check the address
        crc_base        = first ? mrfc_pkg::CRC_INIT : crc_reg;
        dly0_next       = item.frame_byte;
        dly1_next       = first ? 8'h00 : dly0_reg;
        func_next       = first ? 8'h00 : func_reg;
        count_next      = first ? 8'h00 : count_reg;
        pend_temp_next  = first ? 16'h0000 : pend_temp_reg;
        pend_rate_next  = first ? 16'h0000 : pend_rate_reg;
        pend_do_next    = first ? 16'h0000 : pend_do_reg;
        pend_fresh_next = first ? 1'b0 : pend_fresh_reg;
        addr_ok_next    = first ? (item.frame_byte == station_address) : addr_ok_reg;

        // CRC trails the stream by two bytes
        if (idx_reg >= IDX_W'(mrfc_pkg::POS_CRC_BEG))
            crc_next = mrfc_pkg::crc_byte(crc_base, dly1_reg);
        else
            crc_next = crc_base;

        case (idx_reg)
            IDX_W'(mrfc_pkg::POS_FUNC):    func_next = item.frame_byte;
            IDX_W'(mrfc_pkg::POS_COUNT):   count_next = item.frame_byte;
            IDX_W'(mrfc_pkg::POS_TEMP_HI): pend_temp_next[15:8] = item.frame_byte;
            IDX_W'(mrfc_pkg::POS_TEMP_LO): pend_temp_next[7:0] = item.frame_byte;
            IDX_W'(mrfc_pkg::POS_RATE_HI): pend_rate_next[15:8] = item.frame_byte;
            IDX_W'(mrfc_pkg::POS_RATE_LO): pend_rate_next[7:0] = item.frame_byte;
            IDX_W'(mrfc_pkg::POS_DO_HI):   pend_do_next[15:8] = item.frame_byte;
            IDX_W'(mrfc_pkg::POS_DO_LO):   pend_do_next[7:0] = item.frame_byte;
            IDX_W'(mrfc_pkg::POS_FRESH):   pend_fresh_next = item.frame_byte[0];
            default: ;
        endcase

        if (item.is_last)
            idx_next = '0;
        else if (idx_reg <= IDX_W'(MAX_FRAME))
            idx_next = idx_reg + IDX_W'(1);
        else
            idx_next = idx_reg;

        len_err = (idx_reg < IDX_W'(mrfc_pkg::POS_MIN_LAST))
               || (idx_reg >= IDX_W'(MAX_FRAME));
        crc_ok  = (dly1_next == crc_next[7:0]) && (dly0_next == crc_next[15:8]);

        update = 1'b0;
        if (len_err)
            status = mrfc_pkg::ST_LENGTH;
        else if (!addr_ok_next)
            status = mrfc_pkg::ST_ADDR;
        else if (!crc_ok)
            status = mrfc_pkg::ST_CRC;
        else if (func_next == mrfc_pkg::READ_FUNC && count_next == mrfc_pkg::SENSOR_COUNT)
        begin
            status = mrfc_pkg::ST_SENSOR;
            update = item.is_last;
        end
        else
            status = mrfc_pkg::ST_VALID;

        held_temp_next = update ? pend_temp_next : held_temp_reg;
        held_rate_next = update ? pend_rate_next : held_rate_reg;
        held_do_next   = update ? pend_do_next : held_do_reg;

        res.status           = status;
        res.function_code    = func_next;
        res.temperature      = held_temp_next;
        res.dissolved_oxygen = held_do_next;
        res.oxygen_rate      = held_rate_next;
        res.fresh            = update && pend_fresh_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            crc_reg        <= mrfc_pkg::CRC_INIT;
            dly0_reg       <= 8'h00;
            dly1_reg       <= 8'h00;
            addr_ok_reg    <= 1'b0;
            func_reg       <= 8'h00;
            count_reg      <= 8'h00;
            pend_temp_reg  <= 16'h0000;
            pend_rate_reg  <= 16'h0000;
            pend_do_reg    <= 16'h0000;
            pend_fresh_reg <= 1'b0;
            held_temp_reg  <= 16'h0000;
            held_rate_reg  <= 16'h0000;
            held_do_reg    <= 16'h0000;
        end
        else if (advance)
        begin
            idx_reg        <= idx_next;
            crc_reg        <= crc_next;
            dly0_reg       <= dly0_next;
            dly1_reg       <= dly1_next;
            addr_ok_reg    <= addr_ok_next;
            func_reg       <= func_next;
            count_reg      <= count_next;
            pend_temp_reg  <= pend_temp_next;
            pend_rate_reg  <= pend_rate_next;
            pend_do_reg    <= pend_do_next;
            pend_fresh_reg <= pend_fresh_next;
            held_temp_reg  <= held_temp_next;
            held_rate_reg  <= held_rate_next;
            held_do_reg    <= held_do_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/modbus_rtu_frame_checker.sv
// Modbus RTU frame checker with oxygen-sensor capture.
// byte_in: one frame byte per request, is_last set on the final byte of a frame.
// result:  one request per frame, issued after its last byte, carrying status
//          (sensor update, valid other frame, address mismatch, bad CRC, length
//          error), the function byte and the held sensor words.
// APB port: register 0 (byte address 0) holds the station address, reset 247.
// Path: a byte enters the input register on acceptance and is checked from there;
// a last byte's result is registered in the result register when that byte advances,
// and result.valid is driven from that register.
// Throughput: one byte per cycle unless a last byte waits on a held result; the CRC is
// an eight-bit unrolled update between the input register and the frame state, so nothing iterates.
// Stall: while a result waits on result.ready, bytes that are not last keep
// flowing; a last byte holds in the input register until the result is taken,
// and byte_in.ready stays low for as long as it waits there.
// Reset: clears the frame position, captured and held words, and both valid flags,
// and loads the CRC initial value; the station address returns to 247.
`default_nettype none

`include "modbus_rtu_frame_checker_macros.svh"

module modbus_rtu_frame_checker #(
    parameter int MAX_FRAME = 256
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [mrfc_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [mrfc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [mrfc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready,
    mrfc_in_if.sink                                byte_in,
    mrfc_out_if.source                             result
);

    logic                s1_valid_reg, s1_valid_next;
    mrfc_pkg::in_item_t  s1_item_reg;
    logic                out_valid_reg, out_valid_next;
    mrfc_pkg::result_t   out_reg;
    mrfc_pkg::result_t   core_res;
    logic [7:0]          station_address;
    logic                advance;
    logic                emit;

    mrfc_apb_regs u_regs (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .station_address (station_address)
    );

    mrfc_frame_core #(
        .MAX_FRAME (MAX_FRAME)
    ) u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .advance         (advance),
        .item            (s1_item_reg),
        .station_address (station_address),
        .res             (core_res)
    );

    // Advance the held byte unless it is a last byte facing a full result register that is not being taken
    assign advance = s1_valid_reg
                  && (!s1_item_reg.is_last || !out_valid_reg || result.ready);
    assign emit    = advance && s1_item_reg.is_last;

    assign byte_in.ready = !s1_valid_reg || advance;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (byte_in.ready)
            s1_valid_next = byte_in.valid;

        out_valid_next = out_valid_reg;
        if (emit)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: load on request, no reset
    always_ff @(posedge clk)
    begin
        if (byte_in.valid && byte_in.ready)
        begin
            s1_item_reg.frame_byte <= byte_in.frame_byte;
            s1_item_reg.is_last    <= byte_in.is_last;
        end
        if (emit)
            out_reg <= core_res;
    end

    assign result.valid            = out_valid_reg;
    assign result.status           = out_reg.status;
    assign result.function_code    = out_reg.function_code;
    assign result.temperature      = out_reg.temperature;
    assign result.dissolved_oxygen = out_reg.dissolved_oxygen;
    assign result.oxygen_rate      = out_reg.oxygen_rate;
    assign result.fresh            = out_reg.fresh;

    // Only a sensor update may carry the fresh flag
    `MRFC_ASSERT_NOW(a_fresh_only_on_update, out_valid_reg && out_reg.status != mrfc_pkg::ST_SENSOR, !out_reg.fresh, "fresh set on a result that is not a sensor update")

    // A last byte blocked by a waiting result must stay in the input register
    `MRFC_ASSERT_NEXT(a_last_byte_held, s1_valid_reg && s1_item_reg.is_last && out_valid_reg && !result.ready, s1_valid_reg && s1_item_reg.is_last, "last byte lost while result stalled")

    // A result appears only after a last byte advances
    `MRFC_ASSERT_NEXT(a_no_spurious_result, !out_valid_reg && !emit, !out_valid_reg, "result raised without a last byte")

endmodule

`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int MAX_FRAME = 256;
    // Give up well past the slowest legal run (every byte and every report stalled).
    localparam int CYCLE_LIMIT = 300000;
    // Register 0 sits at byte address 4*0.
    localparam int STATION_REG_ADDR = 4 * int'(mrfc_pkg::REG_STATION);

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // Register port, held quiet outside writes.
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [mrfc_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [mrfc_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [mrfc_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    mrfc_in_if  byte_if ();
    mrfc_out_if res_if ();

    // Drive the channel inputs from local variables so they are known from time zero.
    logic               send_valid = 1'b0;
    mrfc_pkg::in_item_t send_req = '0;
    logic               take_ready = 1'b0;

    assign byte_if.valid      = send_valid;
    assign byte_if.frame_byte = send_req.frame_byte;
    assign byte_if.is_last    = send_req.is_last;
    assign res_if.ready       = take_ready;

    modbus_rtu_frame_checker #(
        .MAX_FRAME (MAX_FRAME)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .byte_in (byte_if),
        .result  (res_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Frame checker shadow: mirrors the block's state byte by byte.
    // ------------------------------------------------------------------
    logic [7:0]  station_addr = mrfc_pkg::STATION_RESET;
    int unsigned frame_pos = 0;         // bytes seen in the open frame, saturating
    logic [15:0] crc_acc = mrfc_pkg::CRC_INIT;
    logic [7:0]  tail_prev = '0;        // byte two places back
    logic [7:0]  tail_last = '0;        // byte one place back
    logic        addr_match = 1'b0;
    logic [7:0]  func_hold = '0;
    logic [7:0]  count_hold = '0;
    logic [15:0] temp_pend = '0;
    logic [15:0] rate_pend = '0;
    logic [15:0] do_pend = '0;
    logic        fresh_pend = 1'b0;
    logic [15:0] held_temp = '0;
    logic [15:0] held_rate = '0;
    logic [15:0] held_do = '0;

    mrfc_pkg::result_t  due_reports[$]; // reports owed by the block, oldest first
    mrfc_pkg::in_item_t byte_queue[$];  // frame bytes waiting to be offered
    logic [7:0] frame_buf[$];           // frame under construction

    int  errors = 0;
    int  cycles = 0;
    int  bytes_queued = 0;
    int  frames_queued = 0;
    bit  calm = 1'b0;                   // no idling on either side when set
    int  gap_left = 0;
    int  stall_left = 0;
    mrfc_pkg::result_t seen_want;

    // Reflected CRC-16, one byte, LSB first.
    function automatic logic [15:0] frame_crc_step(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ mrfc_pkg::CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Advance the shadow by one accepted byte; on a last byte queue the report it owes.
    function automatic void absorb_byte(input mrfc_pkg::in_item_t req);
        mrfc_pkg::result_t rep;
        int unsigned       pos;
        logic [7:0]        b;
        b = req.frame_byte;
        pos = frame_pos;
        // First byte of a frame: restart the CRC and drop anything left from before.
        if (pos == 0)
        begin
            crc_acc = mrfc_pkg::CRC_INIT;
            tail_prev = '0;
            tail_last = '0;
            func_hold = '0;
            count_hold = '0;
            temp_pend = '0;
            rate_pend = '0;
            do_pend = '0;
            fresh_pend = 1'b0;
            addr_match = (b == station_addr);
        end
        // The CRC runs two bytes behind so the trailing pair never enters it.
        if (pos >= mrfc_pkg::POS_CRC_BEG)
            crc_acc = frame_crc_step(crc_acc, tail_prev);
        case (pos)
            mrfc_pkg::POS_FUNC:    func_hold = b;
            mrfc_pkg::POS_COUNT:   count_hold = b;
            mrfc_pkg::POS_TEMP_HI: temp_pend[15:8] = b;
            mrfc_pkg::POS_TEMP_LO: temp_pend[7:0] = b;
            mrfc_pkg::POS_RATE_HI: rate_pend[15:8] = b;
            mrfc_pkg::POS_RATE_LO: rate_pend[7:0] = b;
            mrfc_pkg::POS_DO_HI:   do_pend[15:8] = b;
            mrfc_pkg::POS_DO_LO:   do_pend[7:0] = b;
            mrfc_pkg::POS_FRESH:   fresh_pend = b[0];
            default: ;
        endcase
        tail_prev = tail_last;
        tail_last = b;
        if (pos <= MAX_FRAME)
            frame_pos = pos + 1;
        if (req.is_last)
        begin
            frame_pos = 0;
            rep.fresh = 1'b0;
            // Length beats address, address beats CRC.
            if (pos < mrfc_pkg::POS_MIN_LAST || pos >= MAX_FRAME)
                rep.status = mrfc_pkg::ST_LENGTH;
            else if (!addr_match)
                rep.status = mrfc_pkg::ST_ADDR;
            else if (tail_prev != crc_acc[7:0] || tail_last != crc_acc[15:8])
                rep.status = mrfc_pkg::ST_CRC;
            else if (func_hold == mrfc_pkg::READ_FUNC && count_hold == mrfc_pkg::SENSOR_COUNT)
            begin
                rep.status = mrfc_pkg::ST_SENSOR;
                held_temp = temp_pend;
                held_rate = rate_pend;
                held_do = do_pend;
                rep.fresh = fresh_pend;
            end
            else
                rep.status = mrfc_pkg::ST_VALID;
            rep.function_code = func_hold;
            rep.temperature = held_temp;
            rep.dissolved_oxygen = held_do;
            rep.oxygen_rate = held_rate;
            due_reports.push_back(rep);
        end
    endfunction

    function automatic void compare_field(input string label, input logic [15:0] want,
                                          input logic [15:0] got);
        if (got !== want)
        begin
            $display("%t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, label, want, got);
            errors++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Byte driver: offer queued bytes, with random idle bursts.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            send_valid <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (send_valid && byte_if.ready)
                absorb_byte(send_req);
            // Hold the request until it is taken; only then pick the next step.
            if (!(send_valid && !byte_if.ready))
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                    send_valid <= 1'b0;
                end
                else if (!calm && $urandom_range(0, 9) == 0)
                begin
                    gap_left <= $urandom_range(0, 6);
                    send_valid <= 1'b0;
                end
                else if (byte_queue.size() != 0)
                begin
                    send_req <= byte_queue.pop_front();
                    send_valid <= 1'b1;
                end
                else
                    send_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Report monitor: take reports with random stall bursts and check them.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            take_ready <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (res_if.valid && take_ready)
            begin
                if (due_reports.size() == 0)
                begin
                    $display("%t: unexpected report, expected none, actual status %0d",
                             $time, res_if.status);
                    errors++;
                end
                else
                begin
                    seen_want = due_reports.pop_front();
                    compare_field("status", 16'(seen_want.status), 16'(res_if.status));
                    compare_field("function_code", 16'(seen_want.function_code),
                                  16'(res_if.function_code));
                    compare_field("temperature", seen_want.temperature, res_if.temperature);
                    compare_field("dissolved_oxygen", seen_want.dissolved_oxygen,
                                  res_if.dissolved_oxygen);
                    compare_field("oxygen_rate", seen_want.oxygen_rate, res_if.oxygen_rate);
                    compare_field("fresh", 16'(seen_want.fresh), 16'(res_if.fresh));
                end
            end
            if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                take_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                stall_left <= $urandom_range(0, 6);
                take_ready <= 1'b0;
            end
            else
                take_ready <= 1'b1;
        end
    end

    // Watchdog: a hung handshake or a missing report ends here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Frame construction
    // ------------------------------------------------------------------

    // Move frame_buf into the byte queue, last flag on its final byte.
    task automatic queue_raw();
        foreach (frame_buf[j])
            byte_queue.push_back('{frame_byte: frame_buf[j],
                                   is_last: (j == frame_buf.size() - 1)});
        bytes_queued += frame_buf.size();
        frames_queued++;
        frame_buf.delete();
    endtask

    // Append the CRC, low byte first; corrupt it when asked, then queue the frame.
    task automatic queue_frame(input bit good_crc);
        logic [15:0] c;
        c = mrfc_pkg::CRC_INIT;
        foreach (frame_buf[j])
            c = frame_crc_step(c, frame_buf[j]);
        if (!good_crc)
            c ^= 16'($urandom_range(1, 16'hFFFF));
        frame_buf.push_back(c[7:0]);
        frame_buf.push_back(c[15:8]);
        queue_raw();
    endtask

    // Start a frame body: address, function, then random bytes up to body_len.
    task automatic fill_body(input logic [7:0] addr, input logic [7:0] func, input int body_len);
        frame_buf.delete();
        frame_buf.push_back(addr);
        if (body_len >= 2)
            frame_buf.push_back(func);
        while (frame_buf.size() < body_len)
            frame_buf.push_back(8'($urandom_range(0, 255)));
    endtask

    // Sensor reply body: function 3 with the matching byte count.
    task automatic fill_sensor(input logic [7:0] addr, input int body_len);
        fill_body(addr, mrfc_pkg::READ_FUNC, body_len);
        if (body_len > mrfc_pkg::POS_COUNT)
            frame_buf[mrfc_pkg::POS_COUNT] = mrfc_pkg::SENSOR_COUNT;
    endtask

    // Mostly well-formed sensor replies, some other valid frames, the rest broken or noise.
    task automatic queue_random_frame();
        int pick;
        logic [7:0] wrong;
        pick = $urandom_range(0, 99);
        wrong = station_addr ^ 8'($urandom_range(1, 255));
        if (pick < 55)
        begin
            fill_sensor(station_addr, ($urandom_range(0, 3) == 0) ? $urandom_range(3, 30) : 19);
            // Spoil the function or the count now and then: a valid other frame.
            if (pick < 4)
                frame_buf[mrfc_pkg::POS_FUNC] = 8'($urandom_range(0, 255));
            else if (pick < 8 && frame_buf.size() > mrfc_pkg::POS_COUNT)
                frame_buf[mrfc_pkg::POS_COUNT] = 8'($urandom_range(0, 255));
            queue_frame(1'b1);
        end
        else if (pick < 70)
        begin
            fill_body(station_addr, 8'($urandom_range(0, 255)), $urandom_range(2, 24));
            queue_frame(1'b1);
        end
        else if (pick < 80)
        begin
            fill_sensor(station_addr, 19);
            queue_frame(1'b0);
        end
        else if (pick < 88)
        begin
            fill_sensor(wrong, 19);
            queue_frame(1'b1);
        end
        else if (pick < 96)
        begin
            // Runt frame: one to three bytes.
            fill_body(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      $urandom_range(1, 3));
            queue_raw();
        end
        else
        begin
            fill_body(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      $urandom_range(4, 30));
            queue_raw();
        end
    endtask

    // Wait until the sender is empty and every owed report has come back.
    task automatic drain();
        do
            @(negedge clk);
        while (byte_queue.size() != 0 || send_valid || due_reports.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    // Setup cycle, then access cycle; the register takes the value on the access edge.
    task automatic write_station(input logic [7:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= mrfc_pkg::APB_ADDR_W'(STATION_REG_ADDR);
        pwdata <= mrfc_pkg::APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        station_addr = value;
    endtask

    // One setting of the station address, then random traffic until the goals are met.
    task automatic run_phase(input logic [7:0] addr, input bit with_long);
        int goal_bytes;
        int goal_frames;
        write_station(addr);
        goal_bytes = bytes_queued + 100;
        goal_frames = frames_queued + 5;
        if (with_long)
        begin
            // Longest legal frame, then one byte too many.
            fill_sensor(station_addr, MAX_FRAME - 2);
            queue_frame(1'b1);
            fill_sensor(station_addr, MAX_FRAME - 1);
            queue_frame(1'b1);
            goal_bytes = bytes_queued + 100;
        end
        while (bytes_queued < goal_bytes || frames_queued < goal_frames)
            queue_random_frame();
        drain();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed frames at the reset station address.
        frame_buf = {8'hFF};                        // single byte: length error, no function
        queue_raw();
        frame_buf = {mrfc_pkg::STATION_RESET, 8'h00};                 // two bytes
        queue_raw();
        frame_buf = {mrfc_pkg::STATION_RESET, mrfc_pkg::READ_FUNC,
                     mrfc_pkg::SENSOR_COUNT};                         // three bytes
        queue_raw();
        frame_buf = {mrfc_pkg::STATION_RESET, 8'h06};                 // shortest good frame
        queue_frame(1'b1);
        frame_buf = {8'h00, mrfc_pkg::READ_FUNC};                     // address mismatch
        queue_frame(1'b1);
        frame_buf = {mrfc_pkg::STATION_RESET, 8'h10};                 // bad CRC
        queue_frame(1'b0);
        // Sensor reply cut short: the unreached words read as zero.
        frame_buf = {mrfc_pkg::STATION_RESET, mrfc_pkg::READ_FUNC, mrfc_pkg::SENSOR_COUNT};
        queue_frame(1'b1);
        drain();

        run_phase(8'h00, 1'b0);
        run_phase(8'hFF, 1'b1);
        run_phase(8'($urandom_range(1, 254)), 1'b0);
        // Last stretch runs flat out on both sides.
        calm = 1'b1;
        run_phase(mrfc_pkg::STATION_RESET, 1'b0);

        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
